FILE: design/lls_pkg.sv
// Package for the logical line splitter: shared types, character codes and limits.
// Used by lls_front, lls_fifo, lls_back and logical_line_splitter.
package lls_pkg;

    // widths and saturation limits
    localparam int CHAR_W     = 16;
    localparam int DEPTH_MAX  = 255;
    localparam int DEPTH_W    = $clog2(DEPTH_MAX + 1);
    localparam int COUNT_W    = 16;
    localparam int COUNT_MAX  = 65535;
    localparam int NRES       = 3;
    localparam int NRES_W     = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // character codes
    localparam logic [CHAR_W-1:0] CH_LF     = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] CH_CR     = CHAR_W'(13);
    localparam logic [CHAR_W-1:0] CH_SPACE  = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CH_QUOTE  = CHAR_W'(34);
    localparam logic [CHAR_W-1:0] CH_SLASH  = CHAR_W'(47);
    localparam logic [CHAR_W-1:0] CH_BSLASH = CHAR_W'(92);
    localparam logic [CHAR_W-1:0] CH_OPEN   = CHAR_W'(123);
    localparam logic [CHAR_W-1:0] CH_BAR    = CHAR_W'(124);
    localparam logic [CHAR_W-1:0] CH_CLOSE  = CHAR_W'(125);

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_EOL  = 2'd1,
        KIND_EOS  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_LINE  = 2'd0,
        PH_SKIP  = 2'd1,
        PH_TRAIL = 2'd2,
        PH_EXACT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SEP_NONE = 2'd0,
        SEP_LF   = 2'd1,
        SEP_CR   = 2'd2
    } t_sep;

    // input item
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              stream_end;
    } t_in_item;

    // result item on the output port
    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  out_code;
        logic [COUNT_W-1:0] line_count;
        logic               found;
        logic               last;
    } t_out_item;

    // one result as produced by the front end (last is added on drain)
    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  code;
        logic [COUNT_W-1:0] count;
        logic               found;
    } t_res;

    // all results of one input item
    typedef struct packed {
        logic [NRES_W-1:0]   cnt;
        t_res [NRES-1:0]     res;
    } t_bundle;

endpackage

FILE: design/logical_line_splitter.sv
// Top level of the logical line splitter.
// Depends on lls_pkg, lls_front, lls_fifo and lls_back.
//
// Takes one character (or an end-of-stream mark) per transfer on push/full and
// returns kept characters, line-end records and end-of-stream records on
// empty/pop, oldest first, with last set on the final result of each input.
// The scanner decides each character combinationally, so one input is taken
// every cycle while the four-entry bundle queue has room. The drain hands out
// one result per cycle while pop is asserted, so an input that yields two or
// three results (a held slash plus the next character, a line end plus the
// next line's first character, or an end of stream) takes that many pops.
// The exact_mode register is written through i_cfg_we/i_cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce it.
module logical_line_splitter
    import lls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic    w_accept;
    logic    w_bundle_valid;
    t_bundle w_bundle_in;
    t_bundle w_bundle_head;
    logic    w_bundle_empty;
    logic    w_bundle_pop;

    assign w_accept = push && !full;

    lls_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (w_accept),
        .i_item         (i_item),
        .o_bundle_valid (w_bundle_valid),
        .o_bundle       (w_bundle_in)
    );

    lls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_bundle_valid),
        .i_wdata (w_bundle_in),
        .i_rd    (w_bundle_pop),
        .o_rdata (w_bundle_head),
        .o_full  (full),
        .o_empty (w_bundle_empty)
    );

    lls_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bundle       (w_bundle_head),
        .i_bundle_empty (w_bundle_empty),
        .i_pop          (pop),
        .o_bundle_pop   (w_bundle_pop),
        .o_empty        (empty),
        .o_result       (o_result)
    );

endmodule

FILE: design/lls_front.sv
// Front end of the logical line splitter: scanner state and per-character decision.
// Depends on lls_pkg; produces one result bundle per input transfer that yields any result.
module lls_front
    import lls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output logic      o_bundle_valid,
    output t_bundle   o_bundle
);

    typedef struct packed {
        t_phase              phase;
        logic                in_quotes;
        logic                ignoring;
        logic                line_started;
        logic [DEPTH_W-1:0]  brace_depth;
        logic [COUNT_W-1:0]  lines_seen;
        logic                held_bslash;   // held char: 1 backslash, 0 slash
        logic                held_valid;
        t_sep                prev_sep;
    } t_scan;

    logic    r_exact_mode;
    t_scan   r_scan;
    t_scan   n_scan;
    t_bundle n_bundle;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_exact_mode <= i_cfg_wdata;
        end
    end

    // per-character step
    always_comb begin
        t_scan             s;
        logic [CHAR_W-1:0] c;
        logic              at_end;
        logic              is_nl;
        logic              do_body;
        logic [NRES_W-1:0] nres;
        t_res [NRES-1:0]   res;

        s       = r_scan;
        c       = i_item.char_code;
        at_end  = i_item.stream_end || (c == '0);
        is_nl   = (c == CH_LF) || (c == CH_CR);
        do_body = 1'b0;
        nres    = '0;
        res     = '0;

        if (at_end) begin
            // flush held character (a backslash is dropped while ignoring), close a started line, mark end of stream
            if (s.held_valid && (!s.held_bslash || !s.ignoring)) begin
                res[nres] = '{KIND_CHAR, s.held_bslash ? CH_BSLASH : CH_SLASH, '0, 1'b0};
                nres = nres + 1'b1;
            end
            if (s.phase == PH_LINE || s.phase == PH_SKIP) begin
                if (s.line_started) begin
                    if (s.lines_seen < COUNT_W'(COUNT_MAX)) begin
                        s.lines_seen = s.lines_seen + 1'b1;
                    end
                    res[nres] = '{KIND_EOL, '0, s.lines_seen, 1'b1};
                    nres = nres + 1'b1;
                end
            end else begin
                res[nres] = '{KIND_EOL, '0, s.lines_seen, s.line_started};
                nres = nres + 1'b1;
            end
            res[nres] = '{KIND_EOS, '0, '0, 1'b0};
            nres = nres + 1'b1;
            s = '0;
        end else begin
            case (s.phase)
                PH_TRAIL: begin
                    if ((s.prev_sep == SEP_LF && c == CH_CR) ||
                        (s.prev_sep == SEP_CR && c == CH_LF)) begin
                        s.prev_sep = SEP_NONE;
                    end else if (is_nl) begin
                        if (s.lines_seen < COUNT_W'(COUNT_MAX)) begin
                            s.lines_seen = s.lines_seen + 1'b1;
                        end
                        s.prev_sep = (c == CH_LF) ? SEP_LF : SEP_CR;
                    end else if (c == CH_BAR) begin
                        s.prev_sep = SEP_NONE;
                    end else begin
                        res[nres] = '{KIND_EOL, '0, s.lines_seen, 1'b1};
                        nres = nres + 1'b1;
                        s = '0;
                        do_body = 1'b1;
                    end
                end
                PH_EXACT: begin
                    if (s.prev_sep == SEP_CR && c == CH_LF) begin
                        s.prev_sep = SEP_NONE;
                    end else begin
                        res[nres] = '{KIND_EOL, '0, s.lines_seen, 1'b1};
                        nres = nres + 1'b1;
                        s = '0;
                        do_body = 1'b1;
                    end
                end
                PH_SKIP: begin
                    s.phase = PH_LINE;
                    do_body = !is_nl;
                end
                default: begin
                    if (s.held_valid) begin
                        // resolve the held slash or backslash
                        s.held_valid = 1'b0;
                        if (s.held_bslash) begin
                            if (is_nl) begin
                                res[nres] = '{KIND_CHAR, CH_SPACE, '0, 1'b0};
                                nres = nres + 1'b1;
                                if (s.lines_seen < COUNT_W'(COUNT_MAX)) begin
                                    s.lines_seen = s.lines_seen + 1'b1;
                                end
                                s.phase = PH_SKIP;
                            end else begin
                                if (!s.ignoring) begin
                                    res[nres] = '{KIND_CHAR, CH_BSLASH, '0, 1'b0};
                                    nres = nres + 1'b1;
                                end
                                do_body = 1'b1;
                            end
                        end else begin
                            if (c == CH_SLASH) begin
                                s.ignoring = 1'b1;
                            end else begin
                                res[nres] = '{KIND_CHAR, CH_SLASH, '0, 1'b0};
                                nres = nres + 1'b1;
                            end
                            do_body = 1'b1;
                        end
                    end else begin
                        do_body = 1'b1;
                    end
                end
            endcase

            // ordinary body character
            if (do_body) begin
                if (is_nl && s.brace_depth == '0) begin
                    if (s.lines_seen < COUNT_W'(COUNT_MAX)) begin
                        s.lines_seen = s.lines_seen + 1'b1;
                    end
                    if (r_exact_mode) begin
                        s.phase    = PH_EXACT;
                        s.prev_sep = (c == CH_CR) ? SEP_CR : SEP_NONE;
                    end else begin
                        s.phase    = PH_TRAIL;
                        s.prev_sep = (c == CH_LF) ? SEP_LF : SEP_CR;
                    end
                end else if (!s.in_quotes && !r_exact_mode && c == CH_BAR) begin
                    s.phase    = PH_TRAIL;
                    s.prev_sep = SEP_NONE;
                end else begin
                    s.line_started = 1'b1;
                    if (is_nl) begin
                        // folded newline inside braces
                        res[nres] = '{KIND_CHAR, CH_SPACE, '0, 1'b0};
                        nres = nres + 1'b1;
                        if (s.lines_seen < COUNT_W'(COUNT_MAX)) begin
                            s.lines_seen = s.lines_seen + 1'b1;
                        end
                        s.phase = PH_SKIP;
                    end else if (!s.in_quotes && c == CH_BSLASH) begin
                        s.held_bslash = 1'b1;
                        s.held_valid  = 1'b1;
                    end else if (!s.in_quotes && c == CH_OPEN) begin
                        if (s.brace_depth < DEPTH_W'(DEPTH_MAX)) begin
                            s.brace_depth = s.brace_depth + 1'b1;
                        end
                    end else if (!s.in_quotes && c == CH_CLOSE && s.brace_depth != '0) begin
                        s.brace_depth = s.brace_depth - 1'b1;
                    end else if (!s.in_quotes && !r_exact_mode && !s.ignoring &&
                                 c == CH_SLASH) begin
                        s.held_bslash = 1'b0;
                        s.held_valid  = 1'b1;
                    end else begin
                        if (c == CH_QUOTE) begin
                            s.in_quotes = !s.in_quotes;
                        end
                        if (!s.ignoring) begin
                            res[nres] = '{KIND_CHAR, c, '0, 1'b0};
                            nres = nres + 1'b1;
                        end
                    end
                end
            end
        end

        n_scan       = s;
        n_bundle.cnt = nres;
        n_bundle.res = res;
    end

    // scanner state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_accept) begin
            r_scan <= n_scan;
        end
    end

    assign o_bundle_valid = i_accept && (n_bundle.cnt != '0);
    assign o_bundle       = n_bundle;

    // an accepted end of stream leaves the scanner in its reset state
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_item.stream_end || i_item.char_code == '0)) |=> (r_scan == '0))
        else $error("scanner state not cleared after end of stream");

    // a held character only exists while in the line body
    a_held_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan.held_valid |-> (r_scan.phase == PH_LINE))
        else $error("held character outside line body");

endmodule

FILE: design/lls_fifo.sv
// Short bundle queue between the splitter front end and the result drain.
// Depends on lls_pkg for the bundle type and depth.
module lls_fifo
    import lls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_bundle i_wdata,
    input  logic    i_rd,
    output t_bundle o_rdata,
    output logic    o_full,
    output logic    o_empty
);

    t_bundle             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wptr;
    logic [FIFO_AW-1:0]  r_rptr;
    logic [FIFO_AW:0]    r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("bundle queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("bundle queue underflow");

endmodule

FILE: design/lls_back.sv
// Result drain of the logical line splitter: walks one bundle result by result.
// Depends on lls_pkg; reads the head of lls_fifo.
module lls_back
    import lls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_bundle,
    input  logic      i_bundle_empty,
    input  logic      i_pop,
    output logic      o_bundle_pop,
    output logic      o_empty,
    output t_out_item o_result
);

    logic [NRES_W-1:0] r_idx;
    logic              w_last;
    t_res              w_res;

    assign w_res  = i_bundle.res[r_idx];
    assign w_last = (r_idx == i_bundle.cnt - 1'b1);

    assign o_empty             = i_bundle_empty;
    assign o_result.kind       = w_res.kind;
    assign o_result.out_code   = w_res.code;
    assign o_result.line_count = w_res.count;
    assign o_result.found      = w_res.found;
    assign o_result.last       = w_last;
    assign o_bundle_pop        = i_pop && !i_bundle_empty && w_last;

    // result index within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_pop && !i_bundle_empty) begin
            r_idx <= w_last ? '0 : r_idx + 1'b1;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_bundle_empty |-> (i_bundle.cnt != '0 && r_idx < i_bundle.cnt))
        else $error("result index outside head bundle");

endmodule
